>>> rtl/core/lzrw3_pkg.sv
// Shared constants and helpers for the LZRW3 block compressor.
`default_nettype none
package lzrw3_pkg;
  localparam int BYTE_W          = 8;
  localparam int POS_W           = 13;
  localparam int HASH_W          = 12;
  localparam int LEN_W           = 14;
  localparam int MATCH_W         = 5;
  localparam int BLOCK_BYTES_DEF = 4096;
  localparam int HASH_ENTRIES    = 4096;
  localparam int MAX_MATCH       = 18;
  localparam int GROUP_DEPTH     = 32;
  localparam int GROUP_ITEMS     = 16;
  localparam int LIMIT_RESET     = 8192;
  localparam logic [POS_W-1:0] START_MARK = POS_W'(4096);
  localparam logic [15:0] HASH_MULT = 16'd40543;

  function automatic logic [BYTE_W-1:0] start_byte(input logic [MATCH_W-1:0] off);
    logic [BYTE_W-1:0] r;
    case (off)
      5'd0, 5'd10: r = 8'h31;
      5'd1, 5'd11: r = 8'h32;
      5'd2, 5'd12: r = 8'h33;
      5'd3, 5'd13: r = 8'h34;
      5'd4, 5'd14: r = 8'h35;
      5'd5, 5'd15: r = 8'h36;
      5'd6, 5'd16: r = 8'h37;
      5'd7, 5'd17: r = 8'h38;
      5'd8:        r = 8'h39;
      5'd9:        r = 8'h30;
      default:     r = 8'h00;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/lzrw3_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzrw3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/lzrw3_hash.sv
// Three-byte hash unit: multiply and register the table index.
`default_nettype none
module lzrw3_hash (
  input  wire logic                            clk,
  input  wire logic [lzrw3_pkg::BYTE_W-1:0]    b0,
  input  wire logic [lzrw3_pkg::BYTE_W-1:0]    b1,
  input  wire logic [lzrw3_pkg::BYTE_W-1:0]    b2,
  output logic      [lzrw3_pkg::HASH_W-1:0]    idx_r
);
  logic [15:0] v;
  logic [31:0] prod;

  assign v    = {b0, 8'h00} ^ {4'h0, b1, 4'h0} ^ {8'h00, b2};
  assign prod = {16'h0000, v} * {16'h0000, lzrw3_pkg::HASH_MULT};

  always_ff @(posedge clk) begin
    idx_r <= prod[lzrw3_pkg::HASH_W+3:4];
  end
endmodule
`default_nettype wire

>>> rtl/core/lzrw3_block_compressor.sv
// Top level: LZRW3 block compressor sequencer, history, hash table and output stage.
// Each input byte is stored, then the items that it unlocks are coded; literal and copy items
// compare up to 18 bytes through the history read ports.
// A group flush sends the two flag bytes and then the item bytes.
// Reset and every block end run a hash table clearing pass with in_stall high.
`default_nettype none
module lzrw3_block_compressor #(
  parameter int BLOCK_BYTES = lzrw3_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_data_byte,
  input  wire logic                             in_last_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_byte,
  output logic                                  out_last,
  output logic                                  out_overrun,
  output logic [13:0]                           out_compressed_length,
  input  wire logic                             cfg_wr_en,
  input  wire logic [13:0]                      cfg_wr_data
);
  localparam int AW = $clog2(BLOCK_BYTES);
  localparam int PW = lzrw3_pkg::POS_W;
  localparam int HW = lzrw3_pkg::HASH_W;
  localparam int LW = lzrw3_pkg::LEN_W;
  localparam int MW = lzrw3_pkg::MATCH_W;
  localparam int GAW = $clog2(lzrw3_pkg::GROUP_DEPTH);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CHK, S_H0, S_H1, S_H2, S_H3, S_H4, S_RD, S_CK,
    S_LIT, S_CP1, S_CP2, S_CP3, S_T0, S_T1, S_DONE, S_END,
    S_ELO, S_EHI, S_ERD, S_EWR
  } state_t;

  state_t state_r, state_nxt;
  logic [HW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] limit_r, limit_nxt;
  logic [PW-1:0] fill_r, fill_nxt, scan_r, scan_nxt, p_r, p_nxt;
  logic          last_r, last_nxt;
  logic [7:0]    lit_r, lit_nxt, b1_r, b1_nxt, txt_r, txt_nxt;
  logic [HW-1:0] idx_r, idx_nxt, slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [MW-1:0] len_r, len_nxt;
  logic          is_start_r, is_start_nxt, copy_r, copy_nxt;
  logic [15:0]   flag_r, flag_nxt, fl_flags_r, fl_flags_nxt;
  logic [4:0]    items_r, items_nxt;
  logic [GAW:0]  gb_r, gb_nxt, fl_cnt_r, fl_cnt_nxt, gi_r, gi_nxt;
  logic [1:0]    pv_r, pv_nxt;
  logic [LW-1:0] oc_r, oc_nxt, fl_len_r, fl_len_nxt;
  logic          latch_r, latch_nxt, fl_last_r, fl_last_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic          out_ovr_r, out_ovr_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic [LW-1:0] out_len_r, out_len_nxt;

  logic          hist_we;
  logic [AW-1:0] hist_a_addr, hist_b_addr;
  logic [7:0]    hist_a_data, hist_b_data;
  logic          tbl_we;
  logic [HW-1:0] tbl_waddr, tbl_raddr;
  logic [PW-1:0] tbl_wdata, tbl_rdata;
  logic          grp_we;
  logic [7:0]    grp_wdata, grp_rdata;
  logic [HW-1:0] hash_idx;

  logic          accept, out_free, eq, flush, fin;
  logic [LW:0]   pa, pa_off, sl;
  logic [15:0]   flags_v;
  logic [4:0]    items_v;
  logic [LW-1:0] oc_v, oc_add;
  logic [GAW:0]  gb_v;
  logic [LW:0]   need;
  logic [7:0]    a_byte;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_overrun = out_ovr_r;
  assign out_compressed_length = out_len_r;
  assign hist_we   = accept;

  assign pa     = (LW+1)'(p_r) + (LW+1)'(len_r);
  assign pa_off = pa - (LW+1)'(lzrw3_pkg::START_MARK);
  assign sl     = (LW+1)'(scan_r) + (LW+1)'(len_r);
  assign a_byte = is_start_r ? txt_r : hist_a_data;
  assign eq     = (a_byte == hist_b_data);
  assign oc_add = oc_r + LW'(2) + LW'(gb_r);

  lzrw3_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_hist_a (
    .clk(clk), .we(hist_we), .waddr(fill_r[AW-1:0]), .wdata(in_data_byte),
    .raddr(hist_a_addr), .rdata(hist_a_data)
  );
  lzrw3_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_hist_b (
    .clk(clk), .we(hist_we), .waddr(fill_r[AW-1:0]), .wdata(in_data_byte),
    .raddr(hist_b_addr), .rdata(hist_b_data)
  );
  lzrw3_ram #(.WIDTH(PW), .DEPTH(lzrw3_pkg::HASH_ENTRIES)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );
  lzrw3_ram #(.WIDTH(8), .DEPTH(lzrw3_pkg::GROUP_DEPTH)) u_grp (
    .clk(clk), .we(grp_we), .waddr(gb_r[GAW-1:0]), .wdata(grp_wdata),
    .raddr(gi_r[GAW-1:0]), .rdata(grp_rdata)
  );
  lzrw3_hash u_hash (
    .clk(clk), .b0(lit_r), .b1(b1_r), .b2(hist_a_data), .idx_r(hash_idx)
  );

  always_comb begin
    state_nxt = state_r;   clr_nxt = clr_r;       limit_nxt = limit_r;
    fill_nxt = fill_r;     scan_nxt = scan_r;     p_nxt = p_r;
    last_nxt = last_r;     lit_nxt = lit_r;       b1_nxt = b1_r;
    txt_nxt = txt_r;       idx_nxt = idx_r;       slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;   len_nxt = len_r;       is_start_nxt = is_start_r;
    copy_nxt = copy_r;     flag_nxt = flag_r;     fl_flags_nxt = fl_flags_r;
    items_nxt = items_r;   gb_nxt = gb_r;         fl_cnt_nxt = fl_cnt_r;
    gi_nxt = gi_r;         pv_nxt = pv_r;         oc_nxt = oc_r;
    fl_len_nxt = fl_len_r; latch_nxt = latch_r;   fl_last_nxt = fl_last_r;
    out_byte_nxt = out_byte_r; out_last_nxt = out_last_r;
    out_ovr_nxt = out_ovr_r;   out_len_nxt = out_len_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    hist_a_addr = scan_r[AW-1:0];
    hist_b_addr = sl[AW-1:0];
    tbl_we = 1'b0; tbl_waddr = clr_r; tbl_wdata = lzrw3_pkg::START_MARK;
    tbl_raddr = hash_idx;
    grp_we = 1'b0; grp_wdata = lit_r;
    flags_v = flag_r; items_v = items_r; flush = 1'b0; fin = 1'b0;
    oc_v = oc_r; gb_v = gb_r; need = '0;

    if (cfg_wr_en) begin
      limit_nxt = cfg_wr_data;
    end

    case (state_r)
      S_CLR: begin
        tbl_we = 1'b1;
        clr_nxt = clr_r + HW'(1);
        fill_nxt = '0; scan_nxt = '0; last_nxt = 1'b0; flag_nxt = '0;
        items_nxt = '0; gb_nxt = '0; pv_nxt = '0; oc_nxt = '0; latch_nxt = 1'b0;
        if (clr_r == HW'(lzrw3_pkg::HASH_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          fill_nxt = fill_r + PW'(1);
          last_nxt = in_last_byte ||
                     ((LW'(fill_r) + LW'(1)) >= LW'(BLOCK_BYTES));
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if ((LW'(scan_r) + LW'(lzrw3_pkg::MAX_MATCH)) <= LW'(fill_r)) begin
          state_nxt = S_H0;
        end else if (last_r) begin
          state_nxt = (scan_r < fill_r) ? S_T0 : S_END;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_H0: begin
        hist_a_addr = scan_r[AW-1:0];
        hist_b_addr = AW'(scan_r + PW'(1));
        state_nxt = S_H1;
      end
      S_H1: begin
        lit_nxt = hist_a_data;
        b1_nxt = hist_b_data;
        hist_a_addr = AW'(scan_r + PW'(2));
        state_nxt = S_H2;
      end
      S_H2: begin
        state_nxt = S_H3;
      end
      S_H3: begin
        idx_nxt = hash_idx;
        tbl_raddr = hash_idx;
        state_nxt = S_H4;
      end
      S_H4: begin
        p_nxt = tbl_rdata;
        len_nxt = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        hist_a_addr = pa[AW-1:0];
        hist_b_addr = sl[AW-1:0];
        is_start_nxt = (pa >= (LW+1)'(lzrw3_pkg::START_MARK));
        txt_nxt = (pa_off < (LW+1)'(lzrw3_pkg::MAX_MATCH)) ?
                  lzrw3_pkg::start_byte(pa_off[MW-1:0]) : 8'h00;
        state_nxt = S_CK;
      end
      S_CK: begin
        if (eq) begin
          len_nxt = len_r + MW'(1);
          state_nxt = (len_r + MW'(1) < MW'(lzrw3_pkg::MAX_MATCH)) ? S_RD : S_CP1;
        end else begin
          state_nxt = (len_r < MW'(3)) ? S_LIT : S_CP1;
        end
      end
      S_LIT: begin
        grp_we = 1'b1;
        grp_wdata = lit_r;
        gb_nxt = gb_r + (GAW+1)'(1);
        tbl_we = pv_r[1];
        tbl_waddr = slot1_r;
        tbl_wdata = scan_r - PW'(2);
        slot1_nxt = slot0_r;
        slot0_nxt = idx_r;
        pv_nxt = {pv_r[0], 1'b1};
        scan_nxt = scan_r + PW'(1);
        copy_nxt = 1'b0;
        state_nxt = S_DONE;
      end
      S_CP1: begin
        grp_we = 1'b1;
        grp_wdata = {idx_r[11:8], 4'(len_r - MW'(3))};
        gb_nxt = gb_r + (GAW+1)'(1);
        tbl_we = pv_r[0] && pv_r[1];
        tbl_waddr = slot1_r;
        tbl_wdata = scan_r - PW'(2);
        state_nxt = S_CP2;
      end
      S_CP2: begin
        grp_we = 1'b1;
        grp_wdata = idx_r[7:0];
        gb_nxt = gb_r + (GAW+1)'(1);
        tbl_we = pv_r[0];
        tbl_waddr = slot0_r;
        tbl_wdata = scan_r - PW'(1);
        pv_nxt = '0;
        state_nxt = S_CP3;
      end
      S_CP3: begin
        tbl_we = 1'b1;
        tbl_waddr = idx_r;
        tbl_wdata = scan_r;
        scan_nxt = scan_r + PW'(len_r);
        copy_nxt = 1'b1;
        state_nxt = S_DONE;
      end
      S_T0: begin
        hist_a_addr = scan_r[AW-1:0];
        state_nxt = S_T1;
      end
      S_T1: begin
        grp_we = 1'b1;
        grp_wdata = hist_a_data;
        gb_nxt = gb_r + (GAW+1)'(1);
        scan_nxt = scan_r + PW'(1);
        copy_nxt = 1'b0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        flags_v = flag_r | (copy_r ? (16'h0001 << items_r[3:0]) : 16'h0000);
        items_v = items_r + 5'd1;
        flush = items_v[4];
        fin = last_r && (scan_r == fill_r);
        if (flush) begin
          oc_v = latch_r ? oc_r : oc_add;
          gb_v = '0;
        end
        need = (LW+1)'(oc_v) + (LW+1)'(2) + (LW+1)'(gb_v);
        latch_nxt = latch_r || (need > (LW+1)'(limit_r));
        oc_nxt = oc_v;
        if (flush) begin
          flag_nxt = '0; items_nxt = '0; gb_nxt = '0;
          fl_flags_nxt = flags_v;
          fl_cnt_nxt = gb_r;
          fl_last_nxt = fin && !latch_nxt;
          fl_len_nxt = oc_v;
          state_nxt = latch_r ? S_CHK : S_ELO;
        end else begin
          flag_nxt = flags_v;
          items_nxt = items_v;
          state_nxt = S_CHK;
        end
      end
      S_END: begin
        if (latch_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt = 8'h00;
            out_last_nxt = 1'b1;
            out_ovr_nxt = 1'b1;
            out_len_nxt = '0;
            state_nxt = S_CLR;
          end
        end else if (items_r != 5'd0) begin
          fl_flags_nxt = flag_r | (16'hFFFF << items_r[3:0]);
          fl_cnt_nxt = gb_r;
          fl_last_nxt = 1'b1;
          fl_len_nxt = oc_add;
          oc_nxt = oc_add;
          flag_nxt = '0; items_nxt = '0; gb_nxt = '0;
          state_nxt = S_ELO;
        end else begin
          state_nxt = S_CLR;
        end
      end
      S_ELO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt = fl_flags_r[7:0];
          out_last_nxt = 1'b0; out_ovr_nxt = 1'b0; out_len_nxt = '0;
          state_nxt = S_EHI;
        end
      end
      S_EHI: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt = fl_flags_r[15:8];
          out_last_nxt = 1'b0; out_ovr_nxt = 1'b0; out_len_nxt = '0;
          gi_nxt = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        state_nxt = S_EWR;
      end
      S_EWR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt = grp_rdata;
          out_ovr_nxt = 1'b0;
          gi_nxt = gi_r + (GAW+1)'(1);
          if (gi_r + (GAW+1)'(1) == fl_cnt_r) begin
            out_last_nxt = fl_last_r;
            out_len_nxt = fl_last_r ? fl_len_r : '0;
            state_nxt = S_CHK;
          end else begin
            out_last_nxt = 1'b0;
            out_len_nxt = '0;
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      limit_r <= LW'(lzrw3_pkg::LIMIT_RESET);
      out_valid_r <= 1'b0;
      fill_r <= '0;
      scan_r <= '0;
      last_r <= 1'b0;
      flag_r <= '0;
      items_r <= '0;
      gb_r <= '0;
      pv_r <= '0;
      oc_r <= '0;
      latch_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      limit_r <= limit_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r <= fill_nxt;
      scan_r <= scan_nxt;
      last_r <= last_nxt;
      flag_r <= flag_nxt;
      items_r <= items_nxt;
      gb_r <= gb_nxt;
      pv_r <= pv_nxt;
      oc_r <= oc_nxt;
      latch_r <= latch_nxt;
    end
    p_r <= p_nxt;
    lit_r <= lit_nxt;
    b1_r <= b1_nxt;
    txt_r <= txt_nxt;
    idx_r <= idx_nxt;
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
    len_r <= len_nxt;
    is_start_r <= is_start_nxt;
    copy_r <= copy_nxt;
    fl_flags_r <= fl_flags_nxt;
    fl_cnt_r <= fl_cnt_nxt;
    fl_last_r <= fl_last_nxt;
    fl_len_r <= fl_len_nxt;
    gi_r <= gi_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_ovr_r <= out_ovr_nxt;
    out_len_r <= out_len_nxt;
  end
endmodule
`default_nettype wire

>>> tb/lzrw3_block_compressor_checker.sv
// Checker for the LZRW3 block compressor: predicts the compressed stream and compares it.
module lzrw3_block_compressor_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic        out_overrun,
  input  logic [13:0] out_compressed_length,
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  b;
    logic        last;
    logic        ovr;
    logic [13:0] len;
  } comp_word_t;

  comp_word_t  stream_q[$];
  logic [13:0] limit;
  logic [7:0]  hist[4096];
  int          table_pos[4096];
  logic [7:0]  grp[32];
  int          flags, n_items, grp_bytes, scan, fill, out_count;
  int          lit_slot[2];
  bit          lit_ok[2];
  bit          ovr_latch;

  function automatic logic [7:0] fetch_byte(int pos);
    logic [7:0] r;
    if (pos >= 4096) r = (pos - 4096 < 18) ? 8'(8'h30 + ((pos - 4096 + 1) % 10)) : 8'h00;
    else r = hist[pos];
    return r;
  endfunction

  function automatic int hash_at(int pos);
    int v;
    v = (int'(fetch_byte(pos)) << 8) ^ (int'(fetch_byte(pos + 1)) << 4) ^ int'(fetch_byte(pos + 2));
    return ((40543 * v) >> 4) & 12'hFFF;
  endfunction

  task automatic start_block();
    for (int i = 0; i < 4096; i++) table_pos[i] = 4096;
    flags = 0; n_items = 0; grp_bytes = 0; scan = 0; fill = 0; out_count = 0;
    lit_ok[0] = 0; lit_ok[1] = 0; ovr_latch = 0;
  endtask

  task automatic push_word(logic [7:0] b);
    stream_q.push_back('{b: b, last: 1'b0, ovr: 1'b0, len: 14'd0});
  endtask

  task automatic put_byte(logic [7:0] b);
    grp[grp_bytes & 31] = b;
    grp_bytes++;
  endtask

  task automatic flush_group(int f);
    if (!ovr_latch) begin
      push_word(f[7:0]);
      push_word(f[15:8]);
      for (int i = 0; i < grp_bytes && i < 32; i++) push_word(grp[i]);
      out_count = (out_count + 2 + grp_bytes) & 16'h3FFF;
    end
    flags = 0; n_items = 0; grp_bytes = 0;
  endtask

  task automatic item_done(bit is_copy);
    if (is_copy) flags |= 1 << (n_items & 15);
    n_items++;
    if (n_items >= 16) flush_group(flags);
    if (out_count + 2 + grp_bytes > int'(limit)) ovr_latch = 1;
  endtask

  task automatic code_item();
    int s, idx, p, mlen;
    s = scan;
    idx = hash_at(s);
    p = table_pos[idx];
    mlen = 0;
    while (mlen < 18 && fetch_byte(p + mlen) == fetch_byte(s + mlen)) mlen++;
    if (mlen < 3) begin
      put_byte(fetch_byte(s));
      if (lit_ok[1]) table_pos[lit_slot[1] & 12'hFFF] = (s - 2) & 16'hFFFF;
      lit_slot[1] = lit_slot[0];
      lit_ok[1] = lit_ok[0];
      lit_slot[0] = idx;
      lit_ok[0] = 1;
      scan = s + 1;
      item_done(0);
    end else begin
      put_byte(8'(((idx & 12'hF00) >> 4) | (mlen - 3)));
      put_byte(8'(idx & 8'hFF));
      if (lit_ok[0]) begin
        if (lit_ok[1]) begin
          table_pos[lit_slot[1] & 12'hFFF] = (s - 2) & 16'hFFFF;
          lit_ok[1] = 0;
        end
        table_pos[lit_slot[0] & 12'hFFF] = (s - 1) & 16'hFFFF;
        lit_ok[0] = 0;
      end
      table_pos[idx] = s;
      scan = s + mlen;
      item_done(1);
    end
  endtask

  task automatic compress_byte(logic [7:0] d, logic lst);
    int n0;
    bit fin;
    n0 = stream_q.size();
    fin = lst;
    if (fill < 4096) hist[fill] = d;
    fill++;
    if (fill >= 4096) fin = 1;
    while (scan + 18 <= fill) code_item();
    if (fin) begin
      while (scan < fill) begin
        put_byte(fetch_byte(scan));
        scan++;
        item_done(0);
      end
      if (ovr_latch) begin
        stream_q.push_back('{b: 8'h00, last: 1'b1, ovr: 1'b1, len: 14'd0});
      end else begin
        if (n_items > 0) flush_group((flags | (16'hFFFF << n_items)) & 16'hFFFF);
        if (stream_q.size() > n0) begin
          stream_q[$].last = 1'b1;
          stream_q[$].len = 14'(out_count);
        end
      end
      start_block();
    end
  endtask

  always @(posedge clk) begin
    comp_word_t exp_w;
    if (!rst_n) begin
      limit = 14'(lzrw3_pkg::LIMIT_RESET);
      stream_q.delete();
      start_block();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (stream_q.size() == 0) begin
          $display("%0t: unexpected word byte=%h last=%b ovr=%b len=%0d", $time, out_byte,
                   out_last, out_overrun, out_compressed_length);
          errors++;
        end else begin
          exp_w = stream_q.pop_front();
          if (exp_w.b !== out_byte || exp_w.last !== out_last || exp_w.ovr !== out_overrun ||
              exp_w.len !== out_compressed_length) begin
            $display("%0t: expected byte=%h last=%b ovr=%b len=%0d, got byte=%h last=%b ovr=%b len=%0d",
                     $time, exp_w.b, exp_w.last, exp_w.ovr, exp_w.len, out_byte, out_last,
                     out_overrun, out_compressed_length);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) compress_byte(in_data_byte, in_last_byte);
      if (cfg_wr_en) limit = cfg_wr_data;
    end
    pending = stream_q.size();
  end

  final begin
    if (stream_q.size() != 0) $display("%0t: %0d words never arrived", $time, stream_q.size());
  end
endmodule

>>> tb/lzrw3_block_compressor_tb.sv
// Testbench top for the LZRW3 block compressor: stimulus, receiver stalls and verdict.
module lzrw3_block_compressor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 0;
  logic        in_last_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_overrun;
  logic [13:0] out_compressed_length;
  logic        cfg_wr_en = 0;
  logic [13:0] cfg_wr_data = 0;
  int          errors, pending;
  int          quiet_cycles = 0;
  bit          tx_fast = 0, rx_fast = 0, rx_hold = 0;
  logic [7:0]  blk[4096];

  always #1 clk = ~clk;

  lzrw3_block_compressor uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte), .out_last(out_last),
    .out_overrun(out_overrun), .out_compressed_length(out_compressed_length),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  lzrw3_block_compressor_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte), .out_last(out_last),
    .out_overrun(out_overrun), .out_compressed_length(out_compressed_length),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 30000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: hold for a random count, then take one word
  initial begin
    int k;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_stall = 1;
        repeat (600) @(negedge clk);
        rx_hold = 0;
      end
      k = rx_fast ? 0 : $urandom_range(0, 3);
      if (k > 0) begin
        out_stall = 1;
        repeat (k - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall = 0;
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  task automatic send_word(logic [7:0] d, logic lst);
    int k;
    k = tx_fast ? 0 : $urandom_range(0, 3);
    repeat (k) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    in_valid = 1;
    in_data_byte = d;
    in_last_byte = lst;
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (4300) @(negedge clk);
  endtask

  task automatic set_limit(logic [13:0] v);
    @(negedge clk);
    cfg_wr_en = 1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic make_block(int n);
    int sz, base, period;
    sz = $urandom_range(0, 2);
    base = $urandom_range(0, 255);
    period = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      if (i >= period && $urandom_range(0, 3) != 0) blk[i] = blk[i - period];
      else if (sz == 0) blk[i] = 8'(base + $urandom_range(0, 1));
      else if (sz == 1) blk[i] = 8'(base + $urandom_range(0, 3));
      else blk[i] = 8'($urandom);
    end
  endtask

  task automatic send_block(int n, bit mark_last);
    for (int i = 0; i < n; i++) send_word(blk[i], mark_last && (i == n - 1));
  endtask

  initial begin
    int n, sent;
    string s;
    repeat (8) @(negedge clk);
    rst_n = 1;
    repeat (4300) @(negedge clk);
    set_limit(14'd8192);

    send_word(8'hFF, 1);
    send_word(8'h00, 0);
    send_word(8'hFF, 1);
    s = "123456789012345678901";
    for (int i = 0; i < 21; i++) blk[i] = s[i];
    send_block(21, 1);
    drain();

    set_limit(14'd2);
    send_word(8'h55, 0);
    send_word(8'hAA, 0);
    send_word(8'h55, 1);
    drain();

    set_limit(14'd40);
    sent = 0;
    while (sent < 300) begin
      if (sent > 60 && sent < 70) begin
        drain();
        set_limit(14'($urandom_range(2, 8192)));
      end else if (sent > 140 && sent < 150) begin
        drain();
        set_limit(14'($urandom_range(20, 300)));
        sent = 150;
      end else if (sent > 220 && sent < 230) begin
        drain();
        set_limit(14'd8192);
        rx_hold = 1;
        sent = 230;
      end
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : $urandom_range(18, 70);
      make_block(n);
      send_block(n, $urandom_range(0, 7) != 0 || n > 60);
      sent += n;
    end
    drain();

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
